// ===== design/lcdt_pkg.sv =====
// Shared types, constants and helpers for the LCD mode timing controller.
package lcdt_pkg;

  // Default sizes
  localparam int SPRITE_SLOTS_DEF     = 40;
  localparam int SPRITES_PER_LINE_DEF = 10;

  // Item codes
  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // Display modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_LCD_CONTROL  = 3'd0;
  localparam logic [2:0] REG_STAT_ENABLES = 3'd1;
  localparam logic [2:0] REG_COMPARE_LINE = 3'd2;
  localparam logic [2:0] REG_SCROLL_X     = 3'd3;
  localparam logic [2:0] REG_WINDOW_Y     = 3'd4;
  localparam logic [2:0] REG_WINDOW_X     = 3'd5;

  // Timing constants
  localparam logic [9:0] LINE_DOTS   = 10'd456;
  localparam logic [9:0] SCAN_DOTS   = 10'd80;
  localparam logic [9:0] HBLANK_BASE = 10'd376;  // line length less scan
  localparam logic [9:0] DOT_MAX     = 10'd1023;
  localparam logic [8:0] DRAW_BASE   = 9'd172;
  localparam logic [9:0] DRAW_MAX    = 10'd289;
  localparam logic [7:0] VBLANK_LINE = 8'd144;
  localparam logic [7:0] LAST_LINE   = 8'd153;
  localparam logic [7:0] WX_LIMIT    = 8'd166;
  localparam logic [8:0] Y_OFFSET    = 9'd16;
  localparam logic [8:0] SHORT_H     = 9'd8;
  localparam logic [8:0] TALL_H      = 9'd16;

  localparam logic [7:0] LCDC_RESET = 8'd145;

  // Input transaction
  typedef struct packed {
    logic       operation;
    logic [6:0] dots;
    logic [5:0] sprite_index;
    logic [7:0] sprite_y;
  } lcdt_in_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] line;
    logic [1:0] mode;
    logic       coincidence;
    logic       stat_request;
    logic       frame_done;
    logic [8:0] draw_length;
  } lcdt_out_t;

  // Sprite store write port
  typedef struct packed {
    logic       en;
    logic [5:0] index;
    logic [7:0] data;
  } lcdt_wr_t;

  // Sprite scan request
  typedef struct packed {
    logic       start;
    logic [7:0] line;
    logic       tall;
    logic       enable;
  } lcdt_scan_t;

  // STAT request for a mode and match flag under the enables
  function automatic logic stat_check(logic [3:0] en, logic [1:0] mode, logic match);
    logic r;
    r = (en[0] && mode == MODE_HBLANK) ||
        (en[1] && mode == MODE_VBLANK) ||
        (en[2] && mode == MODE_OAM)    ||
        (en[3] && match);
    return r;
  endfunction

endpackage

// ===== design/lcd_mode_timing_controller.sv =====
// Top level of the LCD mode timing controller: registers, mode sequencer, result register.
//
// Each input transaction yields one result. A sprite write and most advance items
// produce their result in the cycle after acceptance. The advance that ends OAM scan
// walks the sprite Y memory through its single read port, one slot per cycle, and
// its result appears once that walk is done; no new item is taken while it runs.
// A new item is taken once the previous result has gone or is leaving. Configuration
// writes are registered and are meant for idle periods.
module lcd_mode_timing_controller #(
  parameter int SPRITE_SLOTS     = lcdt_pkg::SPRITE_SLOTS_DEF,
  parameter int SPRITES_PER_LINE = lcdt_pkg::SPRITES_PER_LINE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcdt_pkg::lcdt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lcdt_pkg::lcdt_out_t out_data
);

  import lcdt_pkg::*;

  localparam int CW = $clog2(SPRITES_PER_LINE + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic [7:0] lcd_control;
  logic [3:0] stat_enables;
  logic [7:0] compare_line;
  logic [7:0] scroll_x;
  logic [7:0] window_y;
  logic [7:0] window_x;

  logic       st;
  logic [1:0] mode;
  logic [7:0] line;
  logic [9:0] dot_cnt;
  logic [8:0] draw_dots;
  logic       match;

  logic       accept;
  logic [10:0] sum;
  logic [9:0] cnt_sat;
  logic [9:0] hb;
  logic [7:0] line_inc;
  logic       m;
  logic [1:0] mode_next;
  logic [7:0] line_next;
  logic       match_next;
  logic [9:0] cnt_next;
  logic       req;
  logic       frame;
  logic       scan_go;

  lcdt_wr_t   wr;
  lcdt_scan_t scan;
  logic       scan_done;
  logic [CW-1:0] scan_count;
  logic [9:0] six_n;
  logic       win;
  logic [9:0] dlen_sum;
  logic [8:0] dlen;

  assign in_ready = (st == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Store sprite bytes on write transactions
  assign wr.en    = accept && (in_data.operation == OP_WRITE);
  assign wr.index = in_data.sprite_index;
  assign wr.data  = in_data.sprite_y;

  assign scan.start  = accept && scan_go;
  assign scan.line   = line;
  assign scan.tall   = lcd_control[2];
  assign scan.enable = lcd_control[1];

  lcdt_sprite_store #(
    .SPRITE_SLOTS    (SPRITE_SLOTS),
    .SPRITES_PER_LINE(SPRITES_PER_LINE)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .scan (scan),
    .done (scan_done),
    .count(scan_count)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control  <= LCDC_RESET;
      stat_enables <= '0;
      compare_line <= '0;
      scroll_x     <= '0;
      window_y     <= '0;
      window_x     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LCD_CONTROL:  lcd_control  <= cfg_data;
        REG_STAT_ENABLES: stat_enables <= cfg_data[3:0];
        REG_COMPARE_LINE: compare_line <= cfg_data;
        REG_SCROLL_X:     scroll_x     <= cfg_data;
        REG_WINDOW_Y:     window_y     <= cfg_data;
        REG_WINDOW_X:     window_x     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the dot counter and work out at most one transition
  always_comb begin
    sum        = {1'b0, dot_cnt} + 11'(in_data.dots);
    cnt_sat    = (sum > {1'b0, DOT_MAX}) ? DOT_MAX : sum[9:0];
    hb         = HBLANK_BASE - {1'b0, draw_dots};
    line_inc   = line + 8'd1;
    m          = (line_inc == compare_line);
    mode_next  = mode;
    line_next  = line;
    match_next = match;
    cnt_next   = dot_cnt;
    req        = 1'b0;
    frame      = 1'b0;
    scan_go    = 1'b0;
    if (in_data.operation == OP_ADVANCE && lcd_control[7]) begin
      cnt_next = cnt_sat;
      case (mode)
        MODE_OAM: begin
          if (cnt_sat >= SCAN_DOTS) begin
            cnt_next = cnt_sat - SCAN_DOTS;
            scan_go  = 1'b1;
          end
        end
        MODE_DRAW: begin
          if (cnt_sat >= {1'b0, draw_dots}) begin
            cnt_next  = cnt_sat - {1'b0, draw_dots};
            mode_next = MODE_HBLANK;
            req       = stat_check(stat_enables, MODE_HBLANK, match);
          end
        end
        MODE_HBLANK: begin
          if (cnt_sat >= hb) begin
            cnt_next   = cnt_sat - hb;
            line_next  = line_inc;
            match_next = m;
            req        = m && stat_check(stat_enables, mode, 1'b1);
            if (line_inc == VBLANK_LINE) begin
              mode_next = MODE_VBLANK;
              frame     = 1'b1;
              req       = req || stat_check(stat_enables, MODE_VBLANK, m);
            end else begin
              mode_next = MODE_OAM;
              req       = req || stat_check(stat_enables, MODE_OAM, m);
            end
          end
        end
        default: begin
          if (cnt_sat >= LINE_DOTS) begin
            cnt_next   = cnt_sat - LINE_DOTS;
            line_next  = line_inc;
            match_next = m;
            req        = m && stat_check(stat_enables, mode, 1'b1);
            if (line_inc > LAST_LINE) begin
              line_next = '0;
              mode_next = MODE_OAM;
              req       = req || stat_check(stat_enables, MODE_OAM, m);
            end
          end
        end
      endcase
    end
  end

  // Drawing length from the sprite count, fine scroll and window
  always_comb begin
    six_n    = (10'(scan_count) << 2) + (10'(scan_count) << 1);
    win      = lcd_control[5] && lcd_control[0] && (line >= window_y) &&
               (window_x <= WX_LIMIT);
    dlen_sum = {1'b0, DRAW_BASE} + {7'd0, scroll_x[2:0]} + six_n +
               (win ? 10'd6 : 10'd0);
    dlen     = (dlen_sum > DRAW_MAX) ? DRAW_MAX[8:0] : dlen_sum[8:0];
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      mode      <= MODE_OAM;
      line      <= '0;
      dot_cnt   <= '0;
      draw_dots <= DRAW_BASE;
      match     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (accept) begin
            mode    <= mode_next;
            line    <= line_next;
            match   <= match_next;
            dot_cnt <= cnt_next;
            if (scan_go) begin
              st <= ST_SCAN;
            end
          end
        end
        default: begin
          if (scan_done) begin
            st        <= ST_IDLE;
            mode      <= MODE_DRAW;
            draw_dots <= dlen;
          end
        end
      endcase
      // Raise the result on completion, drop it once taken
      if ((st == ST_IDLE && accept && !scan_go) || (st == ST_SCAN && scan_done)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (st == ST_IDLE && accept && !scan_go) begin
      out_data.line         <= line_next;
      out_data.mode         <= mode_next;
      out_data.coincidence  <= match_next;
      out_data.stat_request <= req;
      out_data.frame_done   <= frame;
      out_data.draw_length  <= draw_dots;
    end else if (st == ST_SCAN && scan_done) begin
      out_data.line         <= line;
      out_data.mode         <= MODE_DRAW;
      out_data.coincidence  <= match;
      out_data.stat_request <= stat_check(stat_enables, MODE_DRAW, match);
      out_data.frame_done   <= 1'b0;
      out_data.draw_length  <= dlen;
    end
  end

endmodule

// ===== design/lcdt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module lcdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/lcdt_sprite_store.sv =====
// Sprite Y store and the sequential scan that counts sprites covering a line.
module lcdt_sprite_store #(
  parameter int SPRITE_SLOTS     = lcdt_pkg::SPRITE_SLOTS_DEF,
  parameter int SPRITES_PER_LINE = lcdt_pkg::SPRITES_PER_LINE_DEF,
  localparam int CW = $clog2(SPRITES_PER_LINE + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  lcdt_pkg::lcdt_wr_t  wr,
  input  lcdt_pkg::lcdt_scan_t scan,
  output logic                done,
  output logic [CW-1:0]       count
);

  import lcdt_pkg::*;

  localparam int AW = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(SPRITE_SLOTS - 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(SPRITES_PER_LINE);

  logic [SPRITE_SLOTS-1:0] valid;
  logic                    wr_ok;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_ptr;
  logic                    issuing;
  logic                    pend;
  logic                    last_pend;
  logic                    vld_q;
  logic [7:0]              rdata;
  logic [8:0]              ly16;
  logic                    tall;
  logic                    enable;
  logic [8:0]              s;
  logic [8:0]              h;
  logic                    hit;

  assign wr_ok   = wr.en && ({1'b0, wr.index} < 7'(SPRITE_SLOTS));
  assign wr_addr = AW'(wr.index);

  lcdt_ram #(.WIDTH(8), .DEPTH(SPRITE_SLOTS)) u_ram (
    .clk  (clk),
    .we   (wr_ok),
    .waddr(wr_addr),
    .wdata(wr.data),
    .re   (issuing),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  // Mark written slots; an unwritten slot reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ok) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Walk the slots one read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      pend      <= 1'b0;
      last_pend <= 1'b0;
      done      <= 1'b0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      pend      <= issuing;
      last_pend <= issuing && (rd_ptr == LAST_SLOT);
      done      <= pend && last_pend;
      if (scan.start) begin
        issuing <= 1'b1;
        rd_ptr  <= '0;
        count   <= '0;
      end else begin
        if (issuing) begin
          if (rd_ptr == LAST_SLOT) begin
            issuing <= 1'b0;
          end else begin
            rd_ptr <= rd_ptr + 1'b1;
          end
        end
        if (pend && hit && enable && count < COUNT_MAX) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  // Capture scan context and the valid bit alongside the read
  always_ff @(posedge clk) begin
    if (scan.start) begin
      ly16   <= {1'b0, scan.line} + Y_OFFSET;
      tall   <= scan.tall;
      enable <= scan.enable;
    end
    if (issuing) begin
      vld_q <= valid[rd_ptr];
    end
  end

  // Coverage test for the slot just read
  always_comb begin
    s   = vld_q ? {1'b0, rdata} : 9'd0;
    h   = tall ? TALL_H : SHORT_H;
    hit = (ly16 >= s) && (ly16 < s + h);
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the LCD mode timing controller.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdt_pkg::*;

  // Register indexes past the last register; writes to them must change nothing
  localparam logic [2:0] REG_SPARE_A = REG_WINDOW_X + 3'd1;
  localparam logic [2:0] REG_SPARE_B = REG_WINDOW_X + 3'd2;
  // Cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  // Cycles to watch for stray results once everything has arrived
  localparam int DRAIN_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  lcdt_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lcdt_out_t out_data;

  // Items waiting to be driven, and status snapshots waiting to be seen
  lcdt_in_t  lcd_items[$];
  lcdt_out_t expected_status[$];

  int send_idle_pct = 37;
  int recv_idle_pct = 61;
  int idle_cycles = 0;
  int mismatches = 0;
  int results_checked = 0;
  int advances_sent = 0;
  int sprite_writes_sent = 0;
  int frames_entered = 0;
  int requests_raised = 0;
  int settings_run = 0;

  // Predictor copy of the registers
  logic [7:0] lcdc_q = LCDC_RESET;
  logic [3:0] stat_en_q = '0;
  logic [7:0] cmp_line_q = '0;
  logic [7:0] scx_q = '0;
  logic [7:0] wy_q = '0;
  logic [7:0] wx_q = '0;

  // Predictor copy of the timing state
  logic [1:0] mode_q = MODE_OAM;
  logic [7:0] line_q = '0;
  logic       match_q = 1'b0;
  int         dot_q = 0;
  int         draw_q = int'(DRAW_BASE);
  logic [7:0] sprite_y_q[SPRITE_SLOTS_DEF] = '{default: '0};

  lcd_mode_timing_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Interrupt request for the current mode and line match under the enables
  function automatic logic stat_raised();
    return (stat_en_q[0] && mode_q == MODE_HBLANK) ||
           (stat_en_q[1] && mode_q == MODE_VBLANK) ||
           (stat_en_q[2] && mode_q == MODE_OAM) ||
           (stat_en_q[3] && match_q);
  endfunction

  // Drawing length for the current line: scroll, covering sprites, window
  function automatic int drawing_length();
    int len, height, ly16, count, slot;
    len = int'(DRAW_BASE) + int'(scx_q[2:0]);
    height = lcdc_q[2] ? int'(TALL_H) : int'(SHORT_H);
    ly16 = int'(line_q) + int'(Y_OFFSET);
    count = 0;
    if (lcdc_q[1]) begin
      for (slot = 0; slot < SPRITE_SLOTS_DEF && count < SPRITES_PER_LINE_DEF; slot++) begin
        if (ly16 >= int'(sprite_y_q[slot]) && ly16 < int'(sprite_y_q[slot]) + height) begin
          count++;
          len += 6;
        end
      end
    end
    if (lcdc_q[5] && lcdc_q[0] && line_q >= wy_q && wx_q <= WX_LIMIT) len += 6;
    if (len > int'(DRAW_MAX)) len = int'(DRAW_MAX);
    return len;
  endfunction

  // Step to the next line; the match is evaluated only here
  function automatic logic advance_line();
    line_q = line_q + 8'd1;
    if (line_q == cmp_line_q) begin
      match_q = 1'b1;
      return stat_raised();
    end
    match_q = 1'b0;
    return 1'b0;
  endfunction

  function automatic logic enter_mode(input logic [1:0] next_mode);
    mode_q = next_mode;
    return stat_raised();
  endfunction

  // Apply one item to the predictor and return the status it should produce
  function automatic lcdt_out_t predict_status(input lcdt_in_t item);
    lcdt_out_t res;
    logic raise, vblank_entry;
    int hblank_len;
    raise = 1'b0;
    vblank_entry = 1'b0;
    if (item.operation == OP_WRITE) begin
      if (item.sprite_index < SPRITE_SLOTS_DEF) sprite_y_q[item.sprite_index] = item.sprite_y;
    end else if (lcdc_q[7]) begin
      dot_q += int'(item.dots);
      if (dot_q > int'(DOT_MAX)) dot_q = int'(DOT_MAX);
      case (mode_q)
        MODE_OAM: begin
          if (dot_q >= int'(SCAN_DOTS)) begin
            dot_q -= int'(SCAN_DOTS);
            draw_q = drawing_length();
            if (enter_mode(MODE_DRAW)) raise = 1'b1;
          end
        end
        MODE_DRAW: begin
          if (dot_q >= draw_q) begin
            dot_q -= draw_q;
            if (enter_mode(MODE_HBLANK)) raise = 1'b1;
          end
        end
        MODE_HBLANK: begin
          hblank_len = int'(LINE_DOTS) - int'(SCAN_DOTS) - draw_q;
          if (dot_q >= hblank_len) begin
            dot_q -= hblank_len;
            if (advance_line()) raise = 1'b1;
            if (line_q == VBLANK_LINE) begin
              if (enter_mode(MODE_VBLANK)) raise = 1'b1;
              vblank_entry = 1'b1;
            end else if (enter_mode(MODE_OAM)) begin
              raise = 1'b1;
            end
          end
        end
        default: begin
          if (dot_q >= int'(LINE_DOTS)) begin
            dot_q -= int'(LINE_DOTS);
            if (advance_line()) raise = 1'b1;
            // past the last line: wrap without a fresh match evaluation
            if (line_q > LAST_LINE) begin
              line_q = '0;
              if (enter_mode(MODE_OAM)) raise = 1'b1;
            end
          end
        end
      endcase
    end
    res.line = line_q;
    res.mode = mode_q;
    res.coincidence = match_q;
    res.stat_request = raise;
    res.frame_done = vblank_entry;
    res.draw_length = 9'(draw_q);
    return res;
  endfunction

  function automatic lcdt_in_t make_item(input logic op, input int dots, input int slot,
                                         input int y);
    lcdt_in_t item;
    item.operation = op;
    item.dots = 7'(dots);
    item.sprite_index = 6'(slot);
    item.sprite_y = 8'(y);
    return item;
  endfunction

  // Mostly long advances so that whole frames pass; some writes, some past the store
  function automatic lcdt_in_t random_item();
    lcdt_in_t item;
    item.operation = ($urandom_range(99) < 15) ? OP_WRITE : OP_ADVANCE;
    item.dots = ($urandom_range(3) != 0) ? 7'($urandom_range(127, 48)) : 7'($urandom_range(127));
    item.sprite_index = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 40))
                                                 : 6'($urandom_range(39));
    item.sprite_y = 8'($urandom_range(255));
    return item;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Compare one delivered status with the oldest prediction
  task automatic check_status(input lcdt_out_t got);
    lcdt_out_t want;
    if (expected_status.size() == 0) begin
      report_mismatch("result with nothing outstanding", 32'(got), 0);
      return;
    end
    want = expected_status.pop_front();
    if (got.line !== want.line) report_mismatch("line", 32'(got.line), 32'(want.line));
    if (got.mode !== want.mode) report_mismatch("mode", 32'(got.mode), 32'(want.mode));
    if (got.coincidence !== want.coincidence)
      report_mismatch("coincidence", 32'(got.coincidence), 32'(want.coincidence));
    if (got.stat_request !== want.stat_request)
      report_mismatch("stat_request", 32'(got.stat_request), 32'(want.stat_request));
    if (got.frame_done !== want.frame_done)
      report_mismatch("frame_done", 32'(got.frame_done), 32'(want.frame_done));
    if (got.draw_length !== want.draw_length)
      report_mismatch("draw_length", 32'(got.draw_length), 32'(want.draw_length));
    if (want.frame_done) frames_entered++;
    if (want.stat_request) requests_raised++;
    results_checked++;
  endtask

  // Drive one register and keep the predictor copy in step
  task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_LCD_CONTROL:  lcdc_q = value;
      REG_STAT_ENABLES: stat_en_q = value[3:0];
      REG_COMPARE_LINE: cmp_line_q = value;
      REG_SCROLL_X:     scx_q = value;
      REG_WINDOW_Y:     wy_q = value;
      REG_WINDOW_X:     wx_q = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until nothing is queued, in flight or outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (lcd_items.size() != 0 || in_valid || expected_status.size() != 0);
  endtask

  // Drain, reprogram every register, set the idling and queue random items
  task automatic run_settings(input int sender_idle, input int receiver_idle,
                              input logic [7:0] lcdc, input logic [3:0] enables,
                              input logic [7:0] cmp, input logic [7:0] scx,
                              input logic [7:0] wy, input logic [7:0] wx, input int count);
    wait_drained();
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    write_register(REG_LCD_CONTROL, lcdc);
    write_register(REG_STAT_ENABLES, {4'b0, enables});
    write_register(REG_COMPARE_LINE, cmp);
    write_register(REG_SCROLL_X, scx);
    write_register(REG_WINDOW_Y, wy);
    write_register(REG_WINDOW_X, wx);
    @(negedge clk);
    repeat (count) lcd_items.push_back(random_item());
    settings_run++;
  endtask

  // Driver: predict on acceptance, then offer the next item unless idling
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_status.push_back(predict_status(in_data));
        if (in_data.operation == OP_WRITE) sprite_writes_sent++;
        else advances_sent++;
      end
      if (!in_valid || in_ready) begin
        if (lcd_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= lcd_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each delivered status and stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_status(out_data);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Count cycles in which no transaction of any kind happens
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("run hung after %0d results", results_checked);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int slot;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: everything on, tall sprites, full scroll, line one matches
    run_settings(37, 61, 8'hFF, 4'hF, 8'd1, 8'd7, 8'd0, 8'd0, 0);
    write_register(REG_SPARE_A, 8'hA5);
    write_register(REG_SPARE_B, 8'h5A);
    @(negedge clk);
    // more covering sprites than a line allows
    for (slot = 0; slot < 10; slot++) lcd_items.push_back(make_item(OP_WRITE, 0, slot, 16));
    lcd_items.push_back(make_item(OP_WRITE, 127, 39, 12));
    // slots past the store are dropped
    lcd_items.push_back(make_item(OP_WRITE, 0, 40, 16));
    lcd_items.push_back(make_item(OP_WRITE, 0, 63, 255));
    lcd_items.push_back(make_item(OP_ADVANCE, 0, 63, 255));
    lcd_items.push_back(make_item(OP_ADVANCE, 79, 0, 0));
    // scan ends on exactly eighty dots
    lcd_items.push_back(make_item(OP_ADVANCE, 1, 0, 0));
    repeat (2) lcd_items.push_back(make_item(OP_ADVANCE, 127, 0, 0));
    lcd_items.push_back(make_item(OP_ADVANCE, 0, 0, 0));
    repeat (4) lcd_items.push_back(make_item(OP_ADVANCE, 127, 0, 0));
    lcd_items.push_back(make_item(OP_ADVANCE, 80, 0, 0));

    run_settings(37, 61, LCDC_RESET, 4'h0, VBLANK_LINE, 8'd0, 8'd255, WX_LIMIT, 300);
    // display off: advances must leave the state alone
    run_settings(37, 61, 8'h00, 4'hF, 8'd255, 8'd255, 8'd0, 8'd255, 60);

    run_settings(61, 37, 8'hA3, 4'h5, 8'($urandom_range(153)), 8'($urandom), 8'd72,
                 WX_LIMIT + 8'd1, 400);
    run_settings(61, 37, 8'($urandom) | 8'h80, 4'($urandom), LAST_LINE, 8'($urandom),
                 8'($urandom), 8'($urandom), 300);

    // compare against the line past the last, seen just before the wrap
    run_settings(0, 0, 8'hE7, 4'hA, LAST_LINE + 8'd1, 8'd5, 8'd100, 8'd7, 400);
    // line zero is reached by wrapping only, so it never matches
    run_settings(0, 0, 8'h83, 4'h8, 8'd0, 8'd3, 8'd0, 8'd0, 300);
    run_settings(0, 0, 8'($urandom) | 8'h80, 4'h6, 8'($urandom_range(154)), 8'($urandom),
                 8'($urandom_range(143)), 8'($urandom_range(166)), 300);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_status.size() != 0)
      report_mismatch("results never delivered", expected_status.size(), 0);

    $display("covered %0d advances and %0d sprite writes under %0d register settings",
             advances_sent, sprite_writes_sent, settings_run);
    $display("checked %0d results: %0d vblank entries, %0d status requests, %0d mismatches",
             results_checked, frames_entered, requests_raised, mismatches);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
